[src/lfr_pkg.sv]
// ----------------------------------------------------------------------------
// lfr_pkg: LED fade ramp timer shared definitions
// Widths, constants, the speed multiplier mapping and divider handshake types.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int LVL_W   = 8;
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 8;
  localparam int BASE_W  = 20;
  localparam int DIVD_W  = 26;
  localparam int DIVS_W  = 8;
  localparam int CNT_W   = $clog2(DIVD_W);
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int MULT_W  = 7;
  localparam int MAG_W   = 6;

  localparam logic [SPEED_W-1:0] FADE_SPEED_RST = 8'd128;
  localparam logic [DIVD_W-1:0]  BASE_NUM       = 26'd1000000;
  localparam logic [TIME_W-1:0]  INTERVAL_MAX   = '1;
  localparam logic [MAG_W-1:0]   STEP_SCALE     = 6'd10;

  // register index (paddr[PADDR_W-1:2])
  localparam logic [0:0] REG_FADE_SPEED = 1'b0;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  // fs * 100 / 255 - 50, divide by 255 done as shift plus one correction
  function automatic logic signed [MULT_W-1:0] speed_mult(input logic [SPEED_W-1:0] fs);
    logic [14:0]        x;
    logic [6:0]         q0;
    logic [8:0]         r;
    logic [6:0]         q;
    logic signed [7:0]  m;
    x  = 15'(fs) * 15'd100;
    q0 = x[14:8];
    r  = 9'(x[7:0]) + 9'(q0);
    q  = q0 + 7'(r >= 9'd255);
    m  = $signed({1'b0, q}) - 8'sd50;
    return signed'(m[MULT_W-1:0]);
  endfunction

endpackage

[src/lfr_if.sv]
// ----------------------------------------------------------------------------
// lfr_if: poll and level channels
// Valid/ready channels carrying one poll beat and one level beat.
// ----------------------------------------------------------------------------
interface lfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [lfr_pkg::TIME_W-1:0] now_us;
  logic                       light_on;
  logic [lfr_pkg::LVL_W-1:0]  target_level;
  logic                       settings_changed;

  modport source(output valid, now_us, light_on, target_level, settings_changed,
                 input ready);
  modport sink(input valid, now_us, light_on, target_level, settings_changed,
               output ready);
endinterface

interface lfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [lfr_pkg::LVL_W-1:0] pwm_level;
  logic                      level_updated;

  modport source(output valid, pwm_level, level_updated, input ready);
  modport sink(input valid, pwm_level, level_updated, output ready);
endinterface

[src/lfr_div.sv]
// ----------------------------------------------------------------------------
// lfr_div: shared restoring divider
// One quotient bit per cycle, DIVD_W quotient bits per division.
// ----------------------------------------------------------------------------
module lfr_div (
  input  logic              clk,
  input  logic              rst,
  input  lfr_pkg::div_req_t req,
  output lfr_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [lfr_pkg::CNT_W-1:0]    cnt;
  logic [lfr_pkg::DIVS_W-1:0]   rem;
  logic [lfr_pkg::DIVS_W-1:0]   dvs;
  logic [lfr_pkg::DIVD_W-1:0]   dvd;
  logic [lfr_pkg::DIVS_W:0]     trial;
  logic                         qbit;

  assign trial = {rem, dvd[lfr_pkg::DIVD_W-1]};
  assign qbit  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == lfr_pkg::CNT_W'(lfr_pkg::DIVD_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= qbit ? lfr_pkg::DIVS_W'(trial - {1'b0, dvs}) : trial[lfr_pkg::DIVS_W-1:0];
        dvd <= {dvd[lfr_pkg::DIVD_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == lfr_pkg::CNT_W'(lfr_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

[src/lfr_apb.sv]
// ----------------------------------------------------------------------------
// lfr_apb: configuration register port
// APB-style access to the fade speed register.
// ----------------------------------------------------------------------------
module lfr_apb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [lfr_pkg::PDATA_W-1:0]  pwdata,
  output logic [lfr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [lfr_pkg::SPEED_W-1:0]  fade_speed
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = paddr[lfr_pkg::PADDR_W-1:2] == lfr_pkg::REG_FADE_SPEED;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_speed <= lfr_pkg::FADE_SPEED_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      fade_speed <= pwdata[lfr_pkg::SPEED_W-1:0];
    end
  end

  assign prdata = hit ? lfr_pkg::PDATA_W'(fade_speed) : '0;

endmodule

[src/led_fade_ramp_timer.sv]
// ----------------------------------------------------------------------------
// led_fade_ramp_timer: LED brightness fade ramp
// Flow: a jump or a level already at its end goes straight to the result; a zero
//   target goes through the compare; else the divider runs before the compare.
// Interval: shared divider once, or twice when the speed multiplier is nonzero.
// Throughput: one poll at a time; a new poll is taken once the result is loaded.
// Reset (sync, active high): level 0, last update time 0, fade speed 128.
// ----------------------------------------------------------------------------
module led_fade_ramp_timer (
  input  logic                         clk,
  input  logic                         rst,
  lfr_in_if.sink                       in_ch,
  lfr_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [lfr_pkg::PDATA_W-1:0]  pwdata,
  output logic [lfr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV1   = 3'd1;
  localparam logic [2:0] S_DIV2N  = 3'd2;
  localparam logic [2:0] S_DIV2P  = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                          state;
  logic [lfr_pkg::SPEED_W-1:0]         fade_speed;
  logic [lfr_pkg::LVL_W-1:0]           level;
  logic [lfr_pkg::TIME_W-1:0]          last_us;
  logic [lfr_pkg::TIME_W-1:0]          now_r;
  logic [lfr_pkg::LVL_W-1:0]           end_lvl;
  logic [lfr_pkg::BASE_W-1:0]          base;
  logic [lfr_pkg::TIME_W-1:0]          interval;
  logic                                upd;
  logic                                out_valid;
  logic [lfr_pkg::LVL_W-1:0]           out_level;
  logic                                out_upd;

  logic                                in_acc;
  logic [lfr_pkg::LVL_W-1:0]           end_in;
  logic signed [lfr_pkg::MULT_W-1:0]   mult;
  logic [lfr_pkg::MAG_W-1:0]           mult_mag;
  logic [lfr_pkg::MAG_W-1:0]           mul_k;
  logic [lfr_pkg::DIVD_W-1:0]          prod;
  logic [lfr_pkg::TIME_W-1:0]          elapsed;
  logic                                out_free;

  lfr_pkg::div_req_t                   div_req;
  lfr_pkg::div_rsp_t                   div_rsp;

  lfr_apb u_apb (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fade_speed (fade_speed)
  );

  lfr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ch.ready = state == S_IDLE;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign end_in      = in_ch.light_on ? in_ch.target_level : '0;

  assign mult     = lfr_pkg::speed_mult(fade_speed);
  assign mult_mag = mult[lfr_pkg::MULT_W-1] ? lfr_pkg::MAG_W'(-mult) : lfr_pkg::MAG_W'(mult);
  assign mul_k    = mult[lfr_pkg::MULT_W-1] ? mult_mag : lfr_pkg::STEP_SCALE;
  assign prod     = lfr_pkg::DIVD_W'(div_rsp.quotient[lfr_pkg::BASE_W-1:0])
                  * lfr_pkg::DIVD_W'(mul_k);
  assign elapsed  = now_r - last_us;
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    div_req = '0;
    case (state)
      S_IDLE: begin
        if (in_acc && !in_ch.settings_changed && level != end_in &&
            in_ch.target_level != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = lfr_pkg::BASE_NUM;
          div_req.divisor  = in_ch.target_level;
        end
      end
      S_DIV1: begin
        if (div_rsp.done && mult != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = prod;
          div_req.divisor  = mult[lfr_pkg::MULT_W-1] ?
                             lfr_pkg::DIVS_W'(lfr_pkg::STEP_SCALE) :
                             lfr_pkg::DIVS_W'(mult_mag) + lfr_pkg::DIVS_W'(lfr_pkg::STEP_SCALE);
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      level     <= '0;
      last_us   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            now_r   <= in_ch.now_us;
            end_lvl <= end_in;
            upd     <= in_ch.settings_changed;
            if (in_ch.settings_changed) begin
              level   <= end_in;
              last_us <= in_ch.now_us;
              state   <= S_FINISH;
            end else if (level == end_in) begin
              state <= S_FINISH;
            end else if (in_ch.target_level == '0) begin
              interval <= lfr_pkg::INTERVAL_MAX;
              state    <= S_CMP;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            base <= div_rsp.quotient[lfr_pkg::BASE_W-1:0];
            if (mult == '0) begin
              interval <= lfr_pkg::TIME_W'(div_rsp.quotient[lfr_pkg::BASE_W-1:0]);
              state    <= S_CMP;
            end else if (mult[lfr_pkg::MULT_W-1]) begin
              state <= S_DIV2N;
            end else begin
              state <= S_DIV2P;
            end
          end
        end
        S_DIV2N: begin
          if (div_rsp.done) begin
            interval <= lfr_pkg::TIME_W'(base) + lfr_pkg::TIME_W'(div_rsp.quotient);
            state    <= S_CMP;
          end
        end
        S_DIV2P: begin
          if (div_rsp.done) begin
            interval <= lfr_pkg::TIME_W'(div_rsp.quotient);
            state    <= S_CMP;
          end
        end
        S_CMP: begin
          if (elapsed >= interval) begin
            level   <= (end_lvl > level) ? level + 1'b1 : level - 1'b1;
            last_us <= now_r;
            upd     <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_level <= level;
            out_upd   <= upd;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.pwm_level     = out_level;
  assign out_ch.level_updated = out_upd;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("poll accepted but sequencer stayed idle");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |=> level == $past(level) || level == $past(level) + 8'd1 ||
                       level == $past(level) - 8'd1)
    else $error("level moved by more than one step");

  a_div_not_busy: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !out_valid) |=> out_valid && out_ch.pwm_level == $past(level))
    else $error("result beat not loaded with current level");

endmodule
